### design/ethernet_ip_l4_header_parser_top_assert.svh
// Assertion macros for the header parser checker
`ifndef ETHERNET_IP_L4_HEADER_PARSER_TOP_ASSERT_SVH
`define ETHERNET_IP_L4_HEADER_PARSER_TOP_ASSERT_SVH
`define EHP_ASSERT_IMPL(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define EHP_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

### design/ehp_pkg.sv
// Package: phases, flag bits and limits of the header parser
`default_nettype none
package ehp_pkg;
   localparam int unsigned MaxVlanTags   = 4;
   localparam int unsigned MaxExtHeaders = 8;
   localparam logic [15:0] FrameLenMax   = 16'hFFFF;

   localparam logic [15:0] TypeVlan = 16'h8100;
   localparam logic [15:0] TypeQinq = 16'h88A8;
   localparam logic [15:0] TypeIp4  = 16'h0800;
   localparam logic [15:0] TypeIp6  = 16'h86DD;

   localparam logic [7:0] ProtoHop   = 8'd0;
   localparam logic [7:0] ProtoIcmp  = 8'd1;
   localparam logic [7:0] ProtoTcp   = 8'd6;
   localparam logic [7:0] ProtoUdp   = 8'd17;
   localparam logic [7:0] ProtoRoute = 8'd43;
   localparam logic [7:0] ProtoFrag  = 8'd44;
   localparam logic [7:0] ProtoEsp   = 8'd50;
   localparam logic [7:0] ProtoAh    = 8'd51;
   localparam logic [7:0] ProtoIcmp6 = 8'd58;
   localparam logic [7:0] ProtoDest  = 8'd60;

   typedef enum logic [3:0] {
      PH_ETH, PH_VLAN, PH_IP4, PH_IP6, PH_EXT, PH_ESP, PH_TCP, PH_UDP, PH_IDLE
   } phase_type;

   typedef struct packed {
      logic [15:0] ether_kind;
      logic [3:0]  parse_flags;
      logic [7:0]  proto_number;
      logic [7:0]  hop_count;
      logic [63:0] source_high;
      logic [63:0] source_low;
      logic [63:0] dest_high;
      logic [63:0] dest_low;
      logic [31:0] port_pair;
      logic [63:0] sequence_and_ack;
      logic [23:0] window_and_flags;
      logic [31:0] payload_span;
   } record_type;
endpackage
`default_nettype wire

### design/ehp_if.sv
// Valid/ready channel interfaces for bytes and header records
`default_nettype none
interface ehp_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;
   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

interface ehp_rec_if;
   import ehp_pkg::*;
   logic       valid;
   logic       ready;
   record_type rec;
   modport source (output valid, rec, input ready);
   modport sink (input valid, rec, output ready);
endinterface
`default_nettype wire

### design/ehp_core.sv
// Per-byte header parse state and record assembly
`default_nettype none
module ehp_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire logic [7:0]         b,
   input  wire logic               last,
   output ehp_pkg::record_type     rec
);
   import ehp_pkg::*;

   logic [15:0] pos_ff, pos_in, start_ff, start_in, len_ff, len_in, type_ff, type_in;
   logic [2:0]  tags_ff, tags_in;
   logic [3:0]  exts_ff, exts_in;
   phase_type   ph_ff, ph_in;
   logic [63:0] aw_ff [4];
   logic [63:0] aw_in [4];
   logic [63:0] tw0_ff, tw0_in, tw1_ff, tw1_in;
   logic [31:0] ports_ff, ports_in;
   logic [15:0] off_ff, off_in;
   logic        f6_ff, f6_in, fenc_ff, fenc_in, fnet_ff, fnet_in, fpt_ff, fpt_in;
   logic        feth_ff, feth_in, fpay_ff, fpay_in;
   logic [7:0]  proto_ff, proto_in, hops_ff, hops_in, enext_ff, enext_in;

   logic [15:0] rel, nxt, total;
   logic [16:0] hl8;
   logic        ext, inc;

   always_comb begin
      pos_in = pos_ff; start_in = start_ff; len_in = len_ff; type_in = type_ff;
      tags_in = tags_ff; exts_in = exts_ff; ph_in = ph_ff;
      for (int i = 0; i < 4; i++) aw_in[i] = aw_ff[i];
      tw0_in = tw0_ff; tw1_in = tw1_ff; ports_in = ports_ff; off_in = off_ff;
      f6_in = f6_ff; fenc_in = fenc_ff; fnet_in = fnet_ff; fpt_in = fpt_ff;
      feth_in = feth_ff; fpay_in = fpay_ff;
      proto_in = proto_ff; hops_in = hops_ff; enext_in = enext_ff;
      rel = pos_ff - start_ff;
      nxt = pos_ff + 16'd1;
      hl8 = ({9'd0, b} + 17'd1) << 3;
      ext = 1'b0;
      inc = pos_ff != FrameLenMax;
      if (inc) begin
         pos_in = nxt;
         unique case (ph_ff)
            PH_ETH: begin
               if (rel == 16'd12 || rel == 16'd13) type_in = {type_ff[7:0], b};
            end
            PH_VLAN: begin
               if (rel == 16'd2) len_in = {8'd0, b};
               if (rel == 16'd3) begin
                  type_in = {len_ff[7:0], b};
                  tags_in = tags_ff + 3'd1;
               end
            end
            PH_IP4: begin
               if (rel == 16'd0) len_in = {10'd0, b[3:0], 2'b00};
               if (rel == 16'd0 && (b[7:4] != 4'd4 || b[3:0] < 4'd5)) ph_in = PH_IDLE;
               else begin
                  if (rel == 16'd8) hops_in = b;
                  if (rel == 16'd9) proto_in = b;
                  if (rel >= 16'd12 && rel <= 16'd15) aw_in[1] = {aw_ff[1][55:0], b};
                  if (rel >= 16'd16 && rel <= 16'd19) aw_in[3] = {aw_ff[3][55:0], b};
                  if (rel >= 16'd19 && rel + 16'd1 == len_ff) begin
                     fnet_in = 1'b1;
                     start_in = nxt; len_in = '0; ph_in = PH_IDLE;
                     if (proto_ff == ProtoTcp) ph_in = PH_TCP;
                     else if (proto_ff == ProtoUdp) ph_in = PH_UDP;
                     else if (proto_ff == ProtoIcmp || proto_ff == ProtoIcmp6) begin
                        off_in = nxt; fpay_in = 1'b1;
                     end
                  end
               end
            end
            PH_IP6: begin
               if (rel == 16'd6) proto_in = b;
               if (rel == 16'd7) hops_in = b;
               if (rel >= 16'd8 && rel <= 16'd39)
                  aw_in[rel[4:3] - 2'd1] = {aw_ff[rel[4:3] - 2'd1][55:0], b};
               if (rel == 16'd39) begin
                  fnet_in = 1'b1; f6_in = 1'b1; ext = 1'b1;
               end
            end
            PH_EXT: begin
               if (rel == 16'd0) enext_in = b;
               if (rel == 16'd1 && proto_ff != ProtoFrag) len_in = hl8[15:0];
               if (rel >= 16'd1 && rel + 16'd1 == len_in) begin
                  proto_in = enext_ff;
                  exts_in = exts_ff + 4'd1;
                  ext = 1'b1;
               end
            end
            PH_ESP: begin
               if (rel == 16'd1) begin
                  fenc_in = 1'b1; ph_in = PH_IDLE;
               end
            end
            PH_TCP: begin
               if (rel <= 16'd3) ports_in = {ports_ff[23:0], b};
               if (rel >= 16'd4 && rel <= 16'd11) tw0_in = {tw0_ff[55:0], b};
               if (rel == 16'd12) len_in = {10'd0, b[7:4], 2'b00};
               if (rel == 16'd12 && b[7:4] < 4'd5) ph_in = PH_IDLE;
               else begin
                  if (rel == 16'd13) tw1_in[7:0] = tw1_ff[7:0] | b;
                  if (rel == 16'd14) tw1_in[23:16] = tw1_ff[23:16] | b;
                  if (rel == 16'd15) tw1_in[15:8] = tw1_ff[15:8] | b;
                  if (rel >= 16'd19 && rel + 16'd1 == len_ff) begin
                     fpt_in = 1'b1; fpay_in = 1'b1;
                     off_in = start_ff + len_ff; ph_in = PH_IDLE;
                  end
               end
            end
            PH_UDP: begin
               if (rel <= 16'd3) ports_in = {ports_ff[23:0], b};
               if (rel == 16'd7) begin
                  fpt_in = 1'b1; fpay_in = 1'b1;
                  off_in = start_ff + 16'd8; ph_in = PH_IDLE;
               end
            end
            default: ;
         endcase
         // dispatch on the ethertype just completed
         if ((ph_ff == PH_ETH && rel == 16'd13) || (ph_ff == PH_VLAN && rel == 16'd3)) begin
            if (ph_ff == PH_ETH) feth_in = 1'b1;
            start_in = nxt;
            if ((type_in == TypeVlan || type_in == TypeQinq) &&
                {1'b0, tags_in} < 4'(MaxVlanTags)) ph_in = PH_VLAN;
            else if (type_in == TypeIp4) ph_in = PH_IP4;
            else if (type_in == TypeIp6) ph_in = PH_IP6;
            else ph_in = PH_IDLE;
         end
         // walk the IPv6 extension chain
         if (ext) begin
            start_in = nxt;
            if (proto_in == ProtoHop || proto_in == ProtoRoute ||
                proto_in == ProtoDest || proto_in == ProtoFrag) begin
               ph_in = ({1'b0, exts_in} < 5'(MaxExtHeaders)) ? PH_EXT : PH_IDLE;
               len_in = 16'd8;
            end else if (proto_in == ProtoEsp || proto_in == ProtoAh) ph_in = PH_ESP;
            else begin
               len_in = '0; ph_in = PH_IDLE;
               if (proto_in == ProtoTcp) ph_in = PH_TCP;
               else if (proto_in == ProtoUdp) ph_in = PH_UDP;
               else if (proto_in == ProtoIcmp || proto_in == ProtoIcmp6) begin
                  off_in = nxt; fpay_in = 1'b1;
               end
            end
         end
      end
      total = pos_in;
      rec = '0;
      if (feth_in) rec.ether_kind = type_in;
      rec.parse_flags = {fpt_in, fnet_in, fenc_in, f6_in};
      if (fnet_in) begin
         rec.proto_number = proto_in; rec.hop_count = hops_in;
         rec.source_high = aw_in[0]; rec.source_low = aw_in[1];
         rec.dest_high = aw_in[2]; rec.dest_low = aw_in[3];
      end
      if (fpt_in) begin
         rec.port_pair = ports_in; rec.sequence_and_ack = tw0_in;
         rec.window_and_flags = tw1_in[23:0];
      end
      if (fpay_in)
         rec.payload_span = {off_in, (total >= off_in) ? total - off_in : 16'd0};
   end

   always_ff @(posedge clock) begin
      if (reset || (take && last)) begin
         pos_ff <= '0; start_ff <= '0; len_ff <= '0; type_ff <= '0;
         tags_ff <= '0; exts_ff <= '0; ph_ff <= PH_ETH;
         for (int i = 0; i < 4; i++) aw_ff[i] <= '0;
         tw0_ff <= '0; tw1_ff <= '0; ports_ff <= '0; off_ff <= '0;
         f6_ff <= 1'b0; fenc_ff <= 1'b0; fnet_ff <= 1'b0; fpt_ff <= 1'b0;
         feth_ff <= 1'b0; fpay_ff <= 1'b0;
         proto_ff <= '0; hops_ff <= '0; enext_ff <= '0;
      end else if (take) begin
         pos_ff <= pos_in; start_ff <= start_in; len_ff <= len_in; type_ff <= type_in;
         tags_ff <= tags_in; exts_ff <= exts_in; ph_ff <= ph_in;
         for (int i = 0; i < 4; i++) aw_ff[i] <= aw_in[i];
         tw0_ff <= tw0_in; tw1_ff <= tw1_in; ports_ff <= ports_in; off_ff <= off_in;
         f6_ff <= f6_in; fenc_ff <= fenc_in; fnet_ff <= fnet_in; fpt_ff <= fpt_in;
         feth_ff <= feth_in; fpay_ff <= fpay_in;
         proto_ff <= proto_in; hops_ff <= hops_in; enext_ff <= enext_in;
      end
   end
endmodule
`default_nettype wire

### design/ethernet_ip_l4_header_parser_top.sv
// Top level of the streaming Ethernet/IP/L4 header parser
// Usage:
//   req: one frame byte per item, frame_byte in wire order, last_byte on the
//   final byte. rsp: one header record per frame, raised the cycle after the
//   last byte is accepted.
//   Throughput is one byte per cycle while the output register has room or the
//   byte is not last; the parse state is updated by one level of logic per
//   byte, and the record is built from that same next state.
//   A single output register holds the record; while it is full and not taken
//   the block still accepts non-last bytes, and accepts a last byte once the
//   register is empty or being drained in the same cycle.
//   Synchronous reset empties the output register and returns the parse state
//   to the start of a frame. Bytes beyond 65535 are ignored, but last_byte
//   still closes the frame.
`default_nettype none
module ethernet_ip_l4_header_parser_top (
   input wire logic  clock,
   input wire logic  reset,
   ehp_byte_if.sink  req,
   ehp_rec_if.source rsp
);
   import ehp_pkg::*;

   record_type rec, rec_ff;
   logic       valid_ff, take, room;

   assign room = !valid_ff || rsp.ready;
   assign req.ready = room || !req.last_byte;
   assign take = req.valid && req.ready;

   ehp_core u_core (
      .clock(clock), .reset(reset), .take(take),
      .b(req.frame_byte), .last(req.last_byte), .rec(rec)
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (take && req.last_byte) valid_ff <= 1'b1;
      else if (rsp.ready) valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (take && req.last_byte) rec_ff <= rec;
   end

   assign rsp.valid = valid_ff;
   assign rsp.rec   = rec_ff;
endmodule
`default_nettype wire

### design/ehp_checker.sv
// Port-level checker for the header parser, bound to the top level
`default_nettype none
`include "ethernet_ip_l4_header_parser_top_assert.svh"
module ehp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  flags,
   input wire logic [63:0] src_high,
   input wire logic [7:0]  proto
);
   `EHP_ASSERT_NEXT(a_rec_after_last, clock, reset, req_valid && req_ready && req_last, rsp_valid, "no record after last byte")
   `EHP_ASSERT_IMPL(a_last_blocked, clock, reset, rsp_valid && !rsp_ready && req_last, !req_ready, "last byte taken into full output")
   `EHP_ASSERT_IMPL(a_v6_net, clock, reset, rsp_valid && flags[0], flags[2], "ipv6 flag without network flag")
   `EHP_ASSERT_IMPL(a_no_net_zero, clock, reset, rsp_valid && !flags[2], src_high == 64'd0 && proto == 8'd0, "network fields without network flag")
endmodule

bind ethernet_ip_l4_header_parser_top ehp_checker u_ehp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready), .req_last(req.last_byte),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .flags(rsp.rec.parse_flags), .src_high(rsp.rec.source_high),
   .proto(rsp.rec.proto_number)
);
`default_nettype wire

### test/tb_ethernet_ip_l4_header_parser_top.sv
// Self-checking testbench for the streaming Ethernet/IP/L4 header parser
`default_nettype none
module tb_ethernet_ip_l4_header_parser_top;
   import ehp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IdleLimit  = 4000;
   localparam int unsigned MinBytes   = 500;
   localparam logic [7:0] FlagIpv6    = 8'h01;
   localparam logic [7:0] FlagEnc     = 8'h02;
   localparam logic [7:0] FlagNet     = 8'h04;
   localparam logic [7:0] FlagPorts   = 8'h08;
   localparam logic [7:0] FlagEther   = 8'h10;
   localparam logic [7:0] FlagPayload = 8'h20;

   typedef struct {
      int          tags;
      logic [15:0] etype;
      int          ver;
      int          ihl;
      logic [7:0]  proto;
      int          ext_n;
      int          tcp_off;
      int          pay;
      int          cut;
      bit          typed;
      logic [15:0] typed_kind;
   } frame_spec_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ehp_byte_if req_if();
   ehp_rec_if  rsp_if();

   ethernet_ip_l4_header_parser_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // header parse state of the predictor
   int unsigned byte_pos, hdr_start, hdr_len, tag_cnt, ext_cnt;
   logic [15:0] cur_type;
   phase_type   phase;
   logic [63:0] addr_word [4];
   logic [63:0] tcp_word [2];
   logic [31:0] port_word;
   logic [15:0] pay_off;
   logic [7:0]  rec_flags, net_proto, net_hops, ext_next;

   record_type  expected_records [$];
   frame_spec_t directed_rows [$];
   logic [7:0]  frame_bytes [$];
   int unsigned mismatches = 0;
   int unsigned bytes_sent = 0;
   int unsigned records_seen = 0;
   int unsigned frames_sent = 0;
   int unsigned idle_cycles = 0;
   bit          sink_busy_free = 1'b0;
   bit          src_busy_free = 1'b0;

   task automatic clear_frame();
      byte_pos = 0; phase = PH_ETH; hdr_start = 0; hdr_len = 0; cur_type = '0;
      tag_cnt = 0; ext_cnt = 0; addr_word = '{default: '0}; tcp_word = '{default: '0};
      port_word = '0; pay_off = '0; rec_flags = '0; net_proto = '0; net_hops = '0;
      ext_next = '0;
   endtask

   task automatic dispatch_type(int unsigned start);
      hdr_start = start;
      if ((cur_type == TypeVlan || cur_type == TypeQinq) && tag_cnt < MaxVlanTags)
         phase = PH_VLAN;
      else if (cur_type == TypeIp4)
         phase = PH_IP4;
      else if (cur_type == TypeIp6)
         phase = PH_IP6;
      else
         phase = PH_IDLE;
   endtask

   task automatic enter_transport(int unsigned start);
      hdr_start = start;
      hdr_len = 0;
      if (net_proto == ProtoTcp) begin
         phase = PH_TCP;
      end else if (net_proto == ProtoUdp) begin
         phase = PH_UDP;
      end else if (net_proto == ProtoIcmp || net_proto == ProtoIcmp6) begin
         pay_off = start[15:0];
         rec_flags |= FlagPayload;
         phase = PH_IDLE;
      end else begin
         phase = PH_IDLE;
      end
   endtask

   task automatic enter_walk(int unsigned start);
      hdr_start = start;
      if (net_proto == ProtoHop || net_proto == ProtoRoute || net_proto == ProtoDest ||
          net_proto == ProtoFrag) begin
         phase = (ext_cnt < MaxExtHeaders) ? PH_EXT : PH_IDLE;
         hdr_len = 8;
      end else if (net_proto == ProtoEsp || net_proto == ProtoAh) begin
         phase = PH_ESP;
      end else begin
         enter_transport(start);
      end
   endtask

   task automatic parse_byte(int unsigned pos, logic [7:0] b);
      int unsigned rel;
      int unsigned w;
      rel = pos - hdr_start;
      case (phase)
         PH_ETH: begin
            if (rel == 12 || rel == 13) cur_type = {cur_type[7:0], b};
            if (rel == 13) begin
               rec_flags |= FlagEther;
               dispatch_type(pos + 1);
            end
         end
         PH_VLAN: begin
            if (rel == 2) hdr_len = 32'(b);
            if (rel == 3) begin
               cur_type = {hdr_len[7:0], b};
               tag_cnt++;
               dispatch_type(pos + 1);
            end
         end
         PH_IP4: begin
            if (rel == 0) hdr_len = b[3:0] * 4;
            if (rel == 0 && (b[7:4] != 4'd4 || hdr_len < 20)) begin
               phase = PH_IDLE;
            end else begin
               if (rel == 8) net_hops = b;
               if (rel == 9) net_proto = b;
               if (rel >= 12 && rel <= 15) addr_word[1] = {addr_word[1][55:0], b};
               if (rel >= 16 && rel <= 19) addr_word[3] = {addr_word[3][55:0], b};
               if (rel >= 19 && rel + 1 == hdr_len) begin
                  rec_flags |= FlagNet;
                  enter_transport(pos + 1);
               end
            end
         end
         PH_IP6: begin
            if (rel == 6) net_proto = b;
            if (rel == 7) net_hops = b;
            if (rel >= 8 && rel <= 39) begin
               w = (rel - 8) >> 3;
               addr_word[w] = {addr_word[w][55:0], b};
            end
            if (rel == 39) begin
               rec_flags |= FlagNet | FlagIpv6;
               enter_walk(pos + 1);
            end
         end
         PH_EXT: begin
            if (rel == 0) ext_next = b;
            if (rel == 1 && net_proto != ProtoFrag) hdr_len = (b + 1) * 8;
            if (rel >= 1 && rel + 1 == hdr_len) begin
               net_proto = ext_next;
               ext_cnt++;
               enter_walk(pos + 1);
            end
         end
         PH_ESP: begin
            if (rel == 1) begin
               rec_flags |= FlagEnc;
               phase = PH_IDLE;
            end
         end
         PH_TCP: begin
            if (rel <= 3) port_word = {port_word[23:0], b};
            if (rel >= 4 && rel <= 11) tcp_word[0] = {tcp_word[0][55:0], b};
            if (rel == 12) hdr_len = b[7:4] * 4;
            if (rel == 12 && hdr_len < 20) begin
               phase = PH_IDLE;
            end else begin
               if (rel == 13) tcp_word[1][7:0] = b;
               if (rel == 14) tcp_word[1][23:16] = b;
               if (rel == 15) tcp_word[1][15:8] = b;
               if (rel >= 19 && rel + 1 == hdr_len) begin
                  rec_flags |= FlagPorts | FlagPayload;
                  pay_off = 16'(hdr_start + hdr_len);
                  phase = PH_IDLE;
               end
            end
         end
         PH_UDP: begin
            if (rel <= 3) port_word = {port_word[23:0], b};
            if (rel == 7) begin
               rec_flags |= FlagPorts | FlagPayload;
               pay_off = 16'(hdr_start + 8);
               phase = PH_IDLE;
            end
         end
         default: ;
      endcase
   endtask

   // advance the predictor by one item; on the last byte build the record
   task automatic predict_record(logic [7:0] b, logic last, output bit done,
                                 output record_type rec);
      int unsigned total;
      done = 1'b0;
      rec = '0;
      if (byte_pos < 32'(FrameLenMax)) begin
         parse_byte(byte_pos, b);
         byte_pos++;
      end
      if (last) begin
         done = 1'b1;
         total = byte_pos;
         if (rec_flags & FlagEther) rec.ether_kind = cur_type;
         rec.parse_flags = rec_flags[3:0];
         if (rec_flags & FlagNet) begin
            rec.proto_number = net_proto;
            rec.hop_count    = net_hops;
            rec.source_high  = addr_word[0];
            rec.source_low   = addr_word[1];
            rec.dest_high    = addr_word[2];
            rec.dest_low     = addr_word[3];
         end
         if (rec_flags & FlagPorts) begin
            rec.port_pair        = port_word;
            rec.sequence_and_ack = tcp_word[0];
            rec.window_and_flags = tcp_word[1][23:0];
         end
         if (rec_flags & FlagPayload)
            rec.payload_span = {pay_off, (total >= pay_off) ? 16'(total - pay_off) : 16'd0};
         clear_frame();
      end
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_ext();
      case ($urandom_range(0, 3))
         0: return ProtoHop;
         1: return ProtoRoute;
         2: return ProtoDest;
         default: return ProtoFrag;
      endcase
   endfunction

   task automatic push_rand(int n);
      repeat (n) frame_bytes.push_back(8'($urandom));
   endtask

   task automatic build_frame(frame_spec_t s);
      logic [7:0] nxt [$];
      logic [7:0] l4;
      logic [15:0] ty;
      int hl;
      frame_bytes.delete();
      push_rand(12);
      for (int i = 0; i <= s.tags; i++) begin
         ty = (i == s.tags) ? s.etype : ((i % 2) ? TypeQinq : TypeVlan);
         if (i > 0) push_rand(2);
         frame_bytes.push_back(ty[15:8]);
         frame_bytes.push_back(ty[7:0]);
      end
      l4 = s.proto;
      if (s.etype == TypeIp4) begin
         hl = (s.ihl < 5) ? 20 : s.ihl * 4;
         frame_bytes.push_back({4'(s.ver), 4'(s.ihl)});
         push_rand(8);
         frame_bytes.push_back(s.proto);
         push_rand(hl - 10);
      end else if (s.etype == TypeIp6) begin
         for (int i = 0; i < s.ext_n; i++) nxt.push_back(pick_ext());
         nxt.push_back(s.proto);
         frame_bytes.push_back(8'h60);
         push_rand(5);
         frame_bytes.push_back(nxt[0]);
         push_rand(33);
         for (int i = 0; i < s.ext_n; i++) begin
            hl = $urandom_range(0, 2);
            frame_bytes.push_back(nxt[i + 1]);
            frame_bytes.push_back(8'(hl));
            push_rand((nxt[i] == ProtoFrag) ? 6 : (hl + 1) * 8 - 2);
         end
      end
      if (s.etype == TypeIp4 || s.etype == TypeIp6) begin
         if (l4 == ProtoTcp) begin
            push_rand(12);
            frame_bytes.push_back({4'(s.tcp_off), 4'($urandom)});
            push_rand(((s.tcp_off < 5) ? 20 : s.tcp_off * 4) - 13);
         end else if (l4 == ProtoUdp) begin
            push_rand(8);
         end
      end
      push_rand(s.pay);
      if (s.cut > 0 && s.cut < frame_bytes.size())
         frame_bytes = frame_bytes[0:s.cut - 1];
   endtask

   task automatic random_spec(output frame_spec_t s);
      int r;
      s = '{tags: 0, etype: 16'h0, ver: 4, ihl: 5, proto: ProtoTcp, ext_n: 0,
            tcp_off: 5, pay: 0, cut: 0, typed: 0, typed_kind: 16'h0};
      s.tags = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      r = $urandom_range(0, 9);
      s.etype = (r < 4) ? TypeIp4 : (r < 8) ? TypeIp6 : 16'($urandom);
      if ($urandom_range(0, 9) == 0) s.ver = $urandom_range(0, 15);
      s.ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 7);
      r = $urandom_range(0, 9);
      s.proto = (r < 4) ? ProtoTcp : (r < 7) ? ProtoUdp : (r == 7) ? ProtoIcmp :
                (r == 8) ? ((s.etype == TypeIp6) ? ProtoIcmp6 : ProtoIcmp) : 8'($urandom);
      if (s.etype == TypeIp6) begin
         s.ext_n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
         if ($urandom_range(0, 7) == 0) s.proto = $urandom_range(0, 1) ? ProtoEsp : ProtoAh;
      end
      s.tcp_off = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
      s.pay = $urandom_range(0, 8);
      if ($urandom_range(0, 4) == 0) s.cut = $urandom_range(1, 90);
   endtask

   task automatic send_frame(bit typed, logic [15:0] typed_kind);
      bit done;
      record_type rec;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         int g;
         g = src_busy_free ? 0 : gap_len();
         if (g > 0) begin
            req_if.valid = 1'b0;
            repeat (g) @(negedge clock);
         end
         req_if.valid = 1'b1;
         req_if.frame_byte = frame_bytes[i];
         req_if.last_byte = (i == frame_bytes.size() - 1);
         do @(posedge clock); while (!req_if.ready);
         bytes_sent++;
         predict_record(frame_bytes[i], req_if.last_byte, done, rec);
         if (done) begin
            if (typed) begin
               rec = '0;
               rec.ether_kind = typed_kind;
            end
            expected_records.push_back(rec);
         end
         @(negedge clock);
      end
      req_if.valid = 1'b0;
      frames_sent++;
   endtask

   task automatic add_row(int tags, logic [15:0] etype, int ver, int ihl, logic [7:0] proto,
                          int ext_n, int tcp_off, int pay, int cut, bit typed,
                          logic [15:0] typed_kind);
      directed_rows.push_back('{tags, etype, ver, ihl, proto, ext_n, tcp_off, pay, cut,
                                typed, typed_kind});
   endtask

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("[%0t] record %0d: %s got %h expected %h", $realtime, records_seen, field,
               got, want);
   endtask

   // compare each record with the oldest prediction
   always @(posedge clock) begin
      record_type g, e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         g = rsp_if.rec;
         if (expected_records.size() == 0) begin
            report("unexpected record", 64'(g.ether_kind), 64'h0);
         end else begin
            e = expected_records.pop_front();
            if (g.ether_kind !== e.ether_kind)
               report("ether_kind", 64'(g.ether_kind), 64'(e.ether_kind));
            if (g.parse_flags !== e.parse_flags)
               report("parse_flags", 64'(g.parse_flags), 64'(e.parse_flags));
            if (g.proto_number !== e.proto_number)
               report("proto_number", 64'(g.proto_number), 64'(e.proto_number));
            if (g.hop_count !== e.hop_count)
               report("hop_count", 64'(g.hop_count), 64'(e.hop_count));
            if (g.source_high !== e.source_high)
               report("source_high", g.source_high, e.source_high);
            if (g.source_low !== e.source_low) report("source_low", g.source_low, e.source_low);
            if (g.dest_high !== e.dest_high) report("dest_high", g.dest_high, e.dest_high);
            if (g.dest_low !== e.dest_low) report("dest_low", g.dest_low, e.dest_low);
            if (g.port_pair !== e.port_pair)
               report("port_pair", 64'(g.port_pair), 64'(e.port_pair));
            if (g.sequence_and_ack !== e.sequence_and_ack)
               report("sequence_and_ack", g.sequence_and_ack, e.sequence_and_ack);
            if (g.window_and_flags !== e.window_and_flags)
               report("window_and_flags", 64'(g.window_and_flags), 64'(e.window_and_flags));
            if (g.payload_span !== e.payload_span)
               report("payload_span", 64'(g.payload_span), 64'(e.payload_span));
         end
         records_seen++;
      end
   end

   // stall the record channel at random
   always @(negedge clock) begin
      int stall;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (stall > 0) begin
         stall--;
         rsp_if.ready <= 1'b0;
      end else begin
         stall = sink_busy_free ? 0 : gap_len();
         rsp_if.ready <= (stall == 0);
      end
   end

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      frame_spec_t s;
      req_if.valid = 1'b0;
      req_if.frame_byte = '0;
      req_if.last_byte = 1'b0;
      rsp_if.ready = 1'b0;
      clear_frame();
      // tags, type, ver, ihl, proto, ext, tcp offset, payload, cut, typed, kind
      add_row(0, 16'h1234,  4, 5, ProtoTcp,    0, 5, 0, 1,  1, 16'h0000);
      add_row(0, 16'h1234,  4, 5, ProtoTcp,    0, 5, 0, 13, 1, 16'h0000);
      add_row(0, 16'h1234,  4, 5, ProtoTcp,    0, 5, 0, 0,  1, 16'h1234);
      add_row(0, 16'hFFFF,  4, 5, ProtoTcp,    0, 5, 3, 0,  1, 16'hFFFF);
      add_row(5, TypeIp4,   4, 5, ProtoUdp,    0, 5, 2, 0,  1, TypeVlan);
      add_row(0, TypeIp4,   6, 5, ProtoUdp,    0, 5, 2, 0,  1, TypeIp4);
      add_row(0, TypeIp4,   4, 4, ProtoUdp,    0, 5, 2, 0,  1, TypeIp4);
      add_row(0, TypeIp4,   4, 5, ProtoTcp,    0, 5, 4, 0,  0, 16'h0);
      add_row(0, TypeIp4,   4, 5, ProtoTcp,    0, 15, 1, 0, 0, 16'h0);
      add_row(0, TypeIp4,   4, 5, ProtoTcp,    0, 4, 3, 0,  0, 16'h0);
      add_row(0, TypeIp4,   4, 15, ProtoUdp,   0, 5, 5, 0,  0, 16'h0);
      add_row(0, TypeIp4,   4, 5, ProtoIcmp,   0, 5, 6, 0,  0, 16'h0);
      add_row(0, TypeIp4,   4, 5, 8'd255,      0, 5, 2, 0,  0, 16'h0);
      add_row(4, TypeIp4,   4, 5, ProtoUdp,    0, 5, 2, 0,  0, 16'h0);
      add_row(0, TypeIp4,   4, 5, ProtoTcp,    0, 5, 0, 44, 0, 16'h0);
      add_row(0, TypeIp4,   4, 5, ProtoTcp,    0, 5, 0, 25, 0, 16'h0);
      add_row(0, TypeIp6,   6, 5, ProtoTcp,    0, 6, 3, 0,  0, 16'h0);
      add_row(0, TypeIp6,   6, 5, ProtoUdp,    3, 5, 2, 0,  0, 16'h0);
      add_row(0, TypeIp6,   6, 5, ProtoTcp,    9, 5, 2, 0,  0, 16'h0);
      add_row(0, TypeIp6,   6, 5, ProtoEsp,    1, 5, 2, 0,  0, 16'h0);
      add_row(0, TypeIp6,   6, 5, ProtoAh,     0, 5, 1, 0,  0, 16'h0);
      add_row(0, TypeIp6,   6, 5, ProtoIcmp6,  0, 5, 4, 0,  0, 16'h0);
      add_row(0, TypeIp6,   6, 5, ProtoUdp,    0, 5, 0, 60, 0, 16'h0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      src_busy_free = 1'b1;
      sink_busy_free = 1'b1;
      foreach (directed_rows[i]) begin
         build_frame(directed_rows[i]);
         send_frame(directed_rows[i].typed, directed_rows[i].typed_kind);
         if (i == 3) begin
            src_busy_free = 1'b0;
            sink_busy_free = 1'b0;
         end
      end
      // hold the source until every record has drained
      while (expected_records.size() != 0) @(negedge clock);

      bytes_sent = 0;
      for (int f = 0; bytes_sent < MinBytes; f++) begin
         src_busy_free = (f % 25) < 4;
         sink_busy_free = (f % 30) < 3;
         if ($urandom_range(0, 7) == 0) begin
            frame_bytes.delete();
            push_rand($urandom_range(1, 70));
         end else begin
            random_spec(s);
            build_frame(s);
         end
         send_frame(1'b0, 16'h0);
      end

      while (expected_records.size() != 0) @(negedge clock);
      repeat (5) @(posedge clock);
      $display("Sent %0d frames covering tags, IPv4, IPv6 extension chains, TCP/UDP/ICMP,",
               frames_sent);
      $display("truncation and bad headers; %0d records checked.", records_seen);
      if (mismatches == 0 && expected_records.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire

### files.f
+incdir+design
design/ehp_pkg.sv
design/ehp_if.sv
design/ehp_core.sv
design/ethernet_ip_l4_header_parser_top.sv
design/ehp_checker.sv
test/tb_ethernet_ip_l4_header_parser_top.sv
